// ===== rtl/nps3d_pkg.sv =====
// ============================================================================
// nps3d_pkg: shared types and constants for the 3D nearest-point search
// Item layouts, operation codes and controller/datapath command structs.
// ============================================================================
package nps3d_pkg;

    // Default configuration
    localparam int NPS_MAX_POINTS  = 65536;
    localparam int NPS_COORD_WIDTH = 24;

    // Fixed field widths of the item ports
    localparam int OP_W    = 2;
    localparam int COORD_W = 24;
    localparam int INDEX_W = 16;
    localparam int DIST_W  = 25;

    // Operation codes carried by an input item
    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_CAND   = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } point_t;

    // Result item
    typedef struct packed {
        logic                      found;
        logic [INDEX_W-1:0]        closest_index;
        logic signed [COORD_W-1:0] closest_x;
        logic signed [COORD_W-1:0] closest_y;
        logic signed [COORD_W-1:0] closest_z;
        logic [DIST_W-1:0]         distance;
        logic                      overflowed;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_query;   // start: load query, clear search
        logic capture;      // candidate: latch point and abs differences
        logic square;       // square the differences
        logic update;       // sum, compare, keep best
        logic root_start;   // finish: load square root unit
        logic root_step;    // one square root iteration
        logic emit;         // load the result register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic root_last;    // current root step is the final one
        logic out_free;     // result register can take a new item
    } ctl_stat_t;

endpackage

// ===== rtl/nps3d_isqrt.sv =====
// ============================================================================
// nps3d_isqrt: iterative integer square root
// Bit-pair restoring method, one result bit per step, IN_W/2 steps.
// ============================================================================
module nps3d_isqrt #(
    parameter int IN_W = 50
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                step,
    input  logic [IN_W-1:0]     value,
    output logic [IN_W/2-1:0]   root,
    output logic                last
);

    localparam int RT_W = IN_W / 2;

    logic [IN_W-1:0] rem_reg;
    logic [IN_W-1:0] root_reg;
    logic [IN_W-1:0] bit_reg;
    logic [IN_W:0]   trial;
    logic            take;

    // Trial subtraction for the current bit pair
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign take  = ({1'b0, rem_reg} >= trial);

    // Iteration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= '0;
        end
        else if (start)
        begin
            rem_reg  <= value;
            root_reg <= '0;
            bit_reg  <= IN_W'(1) << (IN_W - 2);
        end
        else if (step)
        begin
            if (take)
            begin
                rem_reg  <= rem_reg - trial[IN_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = root_reg[RT_W-1:0];
    assign last = bit_reg[0];

    // The scan bit walks down one pair at a time
    a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bit_reg))
        else $error("isqrt scan bit is not one-hot");

endmodule

// ===== rtl/nps3d_ctrl.sv =====
// ============================================================================
// nps3d_ctrl: controller for the 3D nearest-point search
// Decodes accepted items and sequences the datapath through each operation.
// ============================================================================
module nps3d_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       point_valid,
    output logic                       point_ready,
    input  logic [nps3d_pkg::OP_W-1:0] point_op,
    input  nps3d_pkg::ctl_stat_t       stat,
    output nps3d_pkg::ctl_cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_UPD  = 5'b00100,
        S_ROOT = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        point_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                point_ready = 1'b1;
                if (point_valid)
                begin
                    unique case (point_op)
                        nps3d_pkg::OP_START:
                        begin
                            cmd.load_query = 1'b1;
                        end
                        nps3d_pkg::OP_CAND:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_SQ;
                        end
                        nps3d_pkg::OP_FINISH:
                        begin
                            cmd.root_start = 1'b1;
                            state_next     = S_ROOT;
                        end
                        default:
                        begin
                            // unused code: item dropped
                        end
                    endcase
                end
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is only written into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded while output register busy");

    // A finish always enters the root iteration
    a_root_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_start |=> (state_reg == S_ROOT))
        else $error("finish did not start square root");

endmodule

// ===== rtl/nps3d_dpath.sv =====
// ============================================================================
// nps3d_dpath: datapath for the 3D nearest-point search
// Query and best-so-far registers, distance squaring, compare, square root
// unit and the result register.
// ============================================================================
module nps3d_dpath #(
    parameter int MAX_POINTS  = nps3d_pkg::NPS_MAX_POINTS,
    parameter int COORD_WIDTH = nps3d_pkg::NPS_COORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nps3d_pkg::point_t     point,
    input  nps3d_pkg::ctl_cmd_t   cmd,
    output nps3d_pkg::ctl_stat_t  stat,
    output logic                  result_valid,
    input  logic                  result_ready,
    output nps3d_pkg::result_t    result
);

    localparam int CW    = COORD_WIDTH;
    localparam int SQ_W  = 2 * CW;
    localparam int DSQ_W = SQ_W + 2;
    localparam int RT_W  = DSQ_W / 2;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // |a - b|, always below 2^CW
    function automatic logic [CW-1:0] abs_diff(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        return d[CW] ? CW'(-d) : d[CW-1:0];
    endfunction

    logic signed [CW-1:0] in_x, in_y, in_z;
    logic signed [CW-1:0] query_x_reg, query_y_reg, query_z_reg;
    logic signed [CW-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [CW-1:0]        dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]      sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DSQ_W-1:0]     dsq_sum;
    logic [DSQ_W-1:0]     best_dsq_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic signed [CW-1:0] best_x_reg, best_y_reg, best_z_reg;
    logic [CNT_W-1:0]     seen_reg;
    logic                 ovf_reg;
    logic                 full;
    logic                 found;
    logic [RT_W-1:0]      root;
    logic                 root_last;
    logic                 result_valid_reg;
    nps3d_pkg::result_t   result_reg;
    nps3d_pkg::result_t   result_next;

    // Coordinates use the low COORD_WIDTH bits, as signed values
    assign in_x = point.coord_x[CW-1:0];
    assign in_y = point.coord_y[CW-1:0];
    assign in_z = point.coord_z[CW-1:0];

    // Query point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
            query_z_reg <= '0;
        end
        else if (cmd.load_query)
        begin
            query_x_reg <= in_x;
            query_y_reg <= in_y;
            query_z_reg <= in_z;
        end
    end

    // Candidate capture and per-axis squares
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pt_x_reg <= in_x;
            pt_y_reg <= in_y;
            pt_z_reg <= in_z;
            dx_reg   <= abs_diff(in_x, query_x_reg);
            dy_reg   <= abs_diff(in_y, query_y_reg);
            dz_reg   <= abs_diff(in_z, query_z_reg);
        end
        if (cmd.square)
        begin
            sq_x_reg <= dx_reg * dx_reg;
            sq_y_reg <= dy_reg * dy_reg;
            sq_z_reg <= dz_reg * dz_reg;
        end
    end

    // Squared distance and capacity check
    assign dsq_sum = DSQ_W'(sq_x_reg) + DSQ_W'(sq_y_reg) + DSQ_W'(sq_z_reg);
    assign full    = (seen_reg == CNT_W'(MAX_POINTS));

    // Best-so-far; strictly smaller wins so ties keep the earliest point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dsq_reg <= '0;
            best_idx_reg <= '0;
            best_x_reg   <= '0;
            best_y_reg   <= '0;
            best_z_reg   <= '0;
            seen_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (cmd.load_query)
        begin
            best_dsq_reg <= '0;
            best_idx_reg <= '0;
            best_x_reg   <= '0;
            best_y_reg   <= '0;
            best_z_reg   <= '0;
            seen_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (cmd.update)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                if ((seen_reg == '0) || (dsq_sum < best_dsq_reg))
                begin
                    best_dsq_reg <= dsq_sum;
                    best_idx_reg <= IDX_W'(seen_reg);
                    best_x_reg   <= pt_x_reg;
                    best_y_reg   <= pt_y_reg;
                    best_z_reg   <= pt_z_reg;
                end
                seen_reg <= seen_reg + CNT_W'(1);
            end
        end
    end

    // Square root of the best squared distance
    nps3d_isqrt #(
        .IN_W (DSQ_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .step  (cmd.root_step),
        .value (best_dsq_reg),
        .root  (root),
        .last  (root_last)
    );

    // Result fields, zero when nothing was seen
    assign found = (seen_reg != '0);

    always_comb
    begin
        result_next               = '0;
        result_next.found         = found;
        result_next.overflowed    = ovf_reg;
        if (found)
        begin
            result_next.closest_index = nps3d_pkg::INDEX_W'(best_idx_reg);
            result_next.closest_x     = nps3d_pkg::COORD_W'(best_x_reg);
            result_next.closest_y     = nps3d_pkg::COORD_W'(best_y_reg);
            result_next.closest_z     = nps3d_pkg::COORD_W'(best_z_reg);
            result_next.distance      = nps3d_pkg::DIST_W'(root);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign result         = result_reg;
    assign stat.out_free  = !result_valid_reg || result_ready;
    assign stat.root_last = root_last;

    // Count saturates at capacity
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_W'(MAX_POINTS))
        else $error("candidate count above capacity");

    // Overflow only once the search is full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> full)
        else $error("overflow flag set below capacity");

endmodule

// ===== rtl/nearest_point_search_3d_core.sv =====
// ============================================================================
// nearest_point_search_3d_core: linear nearest-point search in 3D
// Streams candidate points against a query point and reports the closest.
// ============================================================================
// Usage:
//   The point channel carries items of op start (loads the query point and
//   clears the search), candidate (one point) or finish (report). Code 3 is
//   accepted and dropped. The result channel carries one item per finish:
//   found flag, index, coordinates, floor square root distance, overflow.
//   Steps per accepted item (point_ready is low while one is in work):
//     start      loads the query, clears the search
//     candidate  capture differences, square, sum and compare
//     finish     capture, COORD_WIDTH + 1 steps of the bit-pair square root
//                unit, load result register
//   A pending result sits in the output register; start and candidate items
//   are still taken while it waits. A second finish stalls only in its emit
//   state until the receiver has taken the earlier result.
//   Reset clears the query to the origin and empties the search; a finish
//   with no candidates reports found 0 and zero fields.
// ============================================================================
module nearest_point_search_3d_core #(
    parameter int MAX_POINTS  = nps3d_pkg::NPS_MAX_POINTS,
    parameter int COORD_WIDTH = nps3d_pkg::NPS_COORD_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                point_valid,
    output logic                point_ready,
    input  nps3d_pkg::point_t   point,
    output logic                result_valid,
    input  logic                result_ready,
    output nps3d_pkg::result_t  result
);

    nps3d_pkg::ctl_cmd_t  cmd;
    nps3d_pkg::ctl_stat_t stat;

    // Sequencer
    nps3d_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_op    (point.op),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Search datapath
    nps3d_dpath #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .point        (point),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
